@@ hw/rtl/kprd_pkg.sv @@
`default_nettype none

package kprd_pkg;

  // Status codes of a finished report.
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusUnknown    = 2'd1;
  localparam logic [1:0] StatusNoHeader   = 2'd2;

  // Mode codes.
  localparam logic [2:0] ModeUnknown = 3'd0;
  localparam logic [2:0] ModeVote    = 3'd1;
  localparam logic [2:0] ModeExam    = 3'd2;
  localparam logic [2:0] ModeJoin    = 3'd3;
  localparam logic [2:0] ModeChannel = 3'd4;
  localparam logic [2:0] ModeCommand = 3'd5;

  // Byte values with a meaning of their own.
  localparam logic [7:0] EndMarker    = 8'h66;
  localparam logic [7:0] HeaderFirst  = 8'hAA;
  localparam logic [7:0] HeaderSecond = 8'h00;
  localparam logic [7:0] ModeByteVote    = 8'd103;
  localparam logic [7:0] ModeByteExam    = 8'd105;
  localparam logic [7:0] ModeByteJoin    = 8'd108;
  localparam logic [7:0] ModeByteChannel = 8'd110;
  localparam logic [7:0] CountBias       = 8'd15;
  localparam logic [7:0] CountCommand    = 8'd4;
  localparam logic [7:0] AsciiZero       = 8'd48;

  // Byte position of the first value digit.
  localparam int unsigned FirstDigitPos = 7;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         mode_code;
    logic [7:0]         digit_count;
    logic [23:0]        keypad_number;
    logic [31:0]        digit_value;
    logic signed [31:0] user_id;
    logic               numeric_overflow;
  } rec_t;

endpackage

`default_nettype wire

@@ hw/rtl/kprd_if.sv @@
`default_nettype none

interface kprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kprd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         mode_code;
  logic [7:0]         digit_count;
  logic [23:0]        keypad_number;
  logic [31:0]        digit_value;
  logic signed [31:0] user_id;
  logic               numeric_overflow;

  modport source (
    output valid, output status, output mode_code, output digit_count,
    output keypad_number, output digit_value, output user_id, output numeric_overflow,
    input ready
  );
  modport sink (
    input valid, input status, input mode_code, input digit_count,
    input keypad_number, input digit_value, input user_id, input numeric_overflow,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/kprd_parser.sv @@
`default_nettype none

module kprd_parser #(
  parameter int unsigned MAX_REPORT_BYTES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           last_byte_i,
  output kprd_pkg::rec_t      rec_o
);

  localparam int unsigned PosW = $clog2(MAX_REPORT_BYTES + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW + 1 : 9;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_REPORT_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic            stopped_q, stopped_d;
  logic [7:0]      first_q, first_d;
  logic [1:0]      hdr_q, hdr_d;
  logic [2:0]      mode_q, mode_d;
  logic [7:0]      digit_q, digit_d;
  logic [23:0]     keypad_q, keypad_d;
  logic [31:0]     value_q, value_d;
  logic [31:0]     user_q, user_d;
  logic            ovf_q, ovf_d;

  logic [35:0] val_t;
  logic [31:0] val_w;
  logic [35:0] usr_x;
  logic [36:0] usr_t;
  logic        in_digits;

  // Multiply-add by ten done as shifts and adds.
  always_comb begin
    val_t = {value_q, 3'b000} + {3'b000, value_q, 1'b0} + {28'd0, data_byte_i};
    val_w = val_t[31:0];
    if (val_w > 32'(kprd_pkg::AsciiZero)) begin
      val_w = val_w - 32'(kprd_pkg::AsciiZero);
    end
    usr_x = {{4{user_q[31]}}, user_q};
    usr_t = {usr_x[33:0], 3'b000} + {usr_x[35:0], 1'b0} + {29'd0, data_byte_i}
            - 37'(kprd_pkg::AsciiZero);
    in_digits = (CmpW'(pos_q) < (CmpW'(digit_q) + CmpW'(kprd_pkg::FirstDigitPos)));
  end

  always_comb begin
    pos_d     = pos_q;
    stopped_d = stopped_q;
    first_d   = first_q;
    hdr_d     = hdr_q;
    mode_d    = mode_q;
    digit_d   = digit_q;
    keypad_d  = keypad_q;
    value_d   = value_q;
    user_d    = user_q;
    ovf_d     = ovf_q;
    if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
      if (!stopped_q) begin
        if (data_byte_i == kprd_pkg::EndMarker) begin
          stopped_d = 1'b1;
        end else if (pos_q == PosW'(0)) begin
          first_d = data_byte_i;
        end else if (pos_q == PosW'(1)) begin
          if (first_q == kprd_pkg::HeaderFirst && data_byte_i == kprd_pkg::HeaderSecond) begin
            hdr_d = kprd_pkg::StatusOk;
          end else begin
            hdr_d     = kprd_pkg::StatusUnknown;
            stopped_d = 1'b1;
          end
        end else if (pos_q == PosW'(2)) begin
          case (data_byte_i)
            kprd_pkg::ModeByteVote:    mode_d = kprd_pkg::ModeVote;
            kprd_pkg::ModeByteExam:    mode_d = kprd_pkg::ModeExam;
            kprd_pkg::ModeByteJoin:    mode_d = kprd_pkg::ModeJoin;
            kprd_pkg::ModeByteChannel: mode_d = kprd_pkg::ModeChannel;
            default:                   mode_d = kprd_pkg::ModeUnknown;
          endcase
        end else if (pos_q == PosW'(3)) begin
          if (data_byte_i >= kprd_pkg::CountBias) begin
            digit_d = data_byte_i - kprd_pkg::CountBias;
          end else if (data_byte_i == kprd_pkg::CountCommand) begin
            mode_d  = kprd_pkg::ModeCommand;
            digit_d = 8'd1;
          end else begin
            digit_d = data_byte_i;
          end
        end else if (pos_q <= PosW'(6)) begin
          keypad_d = {keypad_q[15:0], data_byte_i};
        end else if (in_digits) begin
          value_d = val_w;
          if (val_t[35:32] != 4'd0) begin
            ovf_d = 1'b1;
          end
        end else if (data_byte_i != 8'd0) begin
          user_d = usr_t[31:0];
          if (!(usr_t[36:31] == '0 || usr_t[36:31] == '1)) begin
            ovf_d = 1'b1;
          end
        end
      end
    end
  end

  // The record reflects the state after the current byte.
  always_comb begin
    rec_o.status           = hdr_d;
    rec_o.mode_code        = mode_d;
    rec_o.digit_count      = digit_d;
    rec_o.keypad_number    = keypad_d;
    rec_o.digit_value      = value_d;
    rec_o.user_id          = user_d;
    rec_o.numeric_overflow = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      stopped_q <= 1'b0;
      first_q   <= '0;
      hdr_q     <= kprd_pkg::StatusNoHeader;
      mode_q    <= kprd_pkg::ModeUnknown;
      digit_q   <= '0;
      keypad_q  <= '0;
      value_q   <= '0;
      user_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q     <= '0;
        stopped_q <= 1'b0;
        first_q   <= '0;
        hdr_q     <= kprd_pkg::StatusNoHeader;
        mode_q    <= kprd_pkg::ModeUnknown;
        digit_q   <= '0;
        keypad_q  <= '0;
        value_q   <= '0;
        user_q    <= '0;
        ovf_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        stopped_q <= stopped_d;
        first_q   <= first_d;
        hdr_q     <= hdr_d;
        mode_q    <= mode_d;
        digit_q   <= digit_d;
        keypad_q  <= keypad_d;
        value_q   <= value_d;
        user_q    <= user_d;
        ovf_q     <= ovf_d;
      end
    end
  end

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax) else $error("byte position past its limit");

  a_bad_header_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q == kprd_pkg::StatusUnknown |-> stopped_q) else $error("bad header not stopped");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> pos_q == '0 && !stopped_q
      && hdr_q == kprd_pkg::StatusNoHeader) else $error("state not cleared after report");

endmodule

`default_nettype wire

@@ hw/rtl/kprd_out_stage.sv @@
`default_nettype none

module kprd_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  kprd_pkg::rec_t      rec_i,
  output logic                free_o,
  kprd_out_if.source          out_o
);

  logic           valid_q, valid_d;
  kprd_pkg::rec_t rec_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.status           = rec_q.status;
  assign out_o.mode_code        = rec_q.mode_code;
  assign out_o.digit_count      = rec_q.digit_count;
  assign out_o.keypad_number    = rec_q.keypad_number;
  assign out_o.digit_value      = rec_q.digit_value;
  assign out_o.user_id          = rec_q.user_id;
  assign out_o.numeric_overflow = rec_q.numeric_overflow;

endmodule

`default_nettype wire

@@ hw/rtl/keypad_report_decoder.sv @@
// Keypad report decoder.
// A report comes in on in_i one byte per transaction; last_byte marks the
// final byte of the report. Exactly one record leaves on out_o for each
// report, after its final byte: header status, mode, digit count, keypad
// number, the accumulated value, the user identifier and an overflow flag.
// Bytes that do not end a report produce no output transaction.
// A byte is taken into an input register and decoded from there by one short
// multiply-by-ten add per accumulator; for a final byte the record is written
// to the output register as the byte leaves the input register, and
// out_o.valid rises with that write. Throughput is one byte per cycle while
// no final byte waits on an occupied output register; the two registers
// together let the next byte enter while a record waits.
// If the receiver stalls, the record is held and a further final byte waits
// in the input register; ordinary bytes keep flowing, and in_i.ready only
// drops when a final byte cannot reach the occupied output register.
// Reset empties both registers and returns the parser to the start of a
// report, with header status "ended before header".
`default_nettype none

module keypad_report_decoder #(
  parameter int unsigned MAX_REPORT_BYTES = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kprd_in_if.sink     in_i,
  kprd_out_if.source  out_o
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic           out_free;
  logic           step;
  logic           load;
  kprd_pkg::rec_t rec;

  // A held byte moves on unless it ends a report and the output is occupied.
  assign step = in_valid_q && (!in_last_q || out_free);
  assign load = step && in_last_q;

  assign in_i.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  kprd_parser #(
    .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .rec_o       (rec)
  );

  kprd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .rec_i  (rec),
    .free_o (out_free),
    .out_o  (out_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !load) else $error("held record overwritten");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready) else $error("empty input register refused a byte");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_last_q && !out_free |-> !in_i.ready)
    else $error("byte accepted over a blocked final byte");

endmodule

`default_nettype wire

@@ bench/kprd_checker.sv @@
`default_nettype none

// Watches both channels of the keypad report decoder, keeps its own copy of the
// parser state, and compares every record that leaves with the one it predicted.
module kprd_checker #(
  parameter int unsigned MAX_REPORT_BYTES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kprd_in_if         byte_mon_i,
  kprd_out_if        rec_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Parser state of the report in progress; the record fields double as the
  // accumulators.
  int unsigned    pos;
  logic           stopped;
  logic [7:0]     hdr_first;
  kprd_pkg::rec_t acc;

  kprd_pkg::rec_t expected_records[$];
  int unsigned    fails;
  int unsigned    records_seen;

  task automatic restart_report();
    pos       = 0;
    stopped   = 1'b0;
    hdr_first = '0;
    acc       = '0;
    acc.status = kprd_pkg::StatusNoHeader;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [63:0] wide;
    longint      t;
    if (pos < MAX_REPORT_BYTES) begin
      if (!stopped) begin
        if (b == kprd_pkg::EndMarker) begin
          stopped = 1'b1;
        end else if (pos == 0) begin
          hdr_first = b;
        end else if (pos == 1) begin
          if (hdr_first == kprd_pkg::HeaderFirst && b == kprd_pkg::HeaderSecond) begin
            acc.status = kprd_pkg::StatusOk;
          end else begin
            acc.status = kprd_pkg::StatusUnknown;
            stopped = 1'b1;
          end
        end else if (pos == 2) begin
          case (b)
            kprd_pkg::ModeByteVote:    acc.mode_code = kprd_pkg::ModeVote;
            kprd_pkg::ModeByteExam:    acc.mode_code = kprd_pkg::ModeExam;
            kprd_pkg::ModeByteJoin:    acc.mode_code = kprd_pkg::ModeJoin;
            kprd_pkg::ModeByteChannel: acc.mode_code = kprd_pkg::ModeChannel;
            default:                   acc.mode_code = kprd_pkg::ModeUnknown;
          endcase
        end else if (pos == 3) begin
          if (b >= kprd_pkg::CountBias) begin
            acc.digit_count = b - kprd_pkg::CountBias;
          end else if (b == kprd_pkg::CountCommand) begin
            acc.mode_code   = kprd_pkg::ModeCommand;
            acc.digit_count = 8'd1;
          end else begin
            acc.digit_count = b;
          end
        end else if (pos < kprd_pkg::FirstDigitPos) begin
          acc.keypad_number = {acc.keypad_number[15:0], b};
        end else if (pos < acc.digit_count + kprd_pkg::FirstDigitPos) begin
          wide = {32'd0, acc.digit_value} * 64'd10 + {56'd0, b};
          if (wide[63:32] != '0) acc.numeric_overflow = 1'b1;
          acc.digit_value = wide[31:0];
          if (acc.digit_value > kprd_pkg::AsciiZero) begin
            acc.digit_value = acc.digit_value - kprd_pkg::AsciiZero;
          end
        end else if (b != 8'd0) begin
          t = acc.user_id;
          t = t * 10 + int'(b) - int'(kprd_pkg::AsciiZero);
          // The result fits in 32 signed bits only if bits 63..31 all agree.
          if (t[63:31] != '0 && t[63:31] != '1) acc.numeric_overflow = 1'b1;
          acc.user_id = t[31:0];
        end
      end
      pos++;
    end
    if (fin) begin
      expected_records.insert(expected_records.size(), acc);
      restart_report();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kprd_pkg::rec_t got;
    kprd_pkg::rec_t want;
    if (!rst_ni) begin
      restart_report();
      expected_records.delete();
      fails        = 0;
      records_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Outgoing record first, so that a record can only match an expectation
      // pushed in an earlier cycle.
      if (rec_mon_i.valid && rec_mon_i.ready) begin
        got.status           = rec_mon_i.status;
        got.mode_code        = rec_mon_i.mode_code;
        got.digit_count      = rec_mon_i.digit_count;
        got.keypad_number    = rec_mon_i.keypad_number;
        got.digit_value      = rec_mon_i.digit_value;
        got.user_id          = rec_mon_i.user_id;
        got.numeric_overflow = rec_mon_i.numeric_overflow;
        if (expected_records.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("record %0d arrived with no report pending: st=%0d mode=%0d dc=%0d",
                     records_seen, got.status, got.mode_code, got.digit_count);
          end
        end else begin
          want = expected_records.pop_front();
          if (got.status !== want.status || got.mode_code !== want.mode_code ||
              got.digit_count !== want.digit_count ||
              got.keypad_number !== want.keypad_number ||
              got.digit_value !== want.digit_value || got.user_id !== want.user_id ||
              got.numeric_overflow !== want.numeric_overflow) begin
            fails++;
            if (fails <= 10) begin
              $display({"record %0d mismatch: expected st=%0d mode=%0d dc=%0d",
                        " kp=%h val=%h uid=%h ovf=%b"},
                       records_seen, want.status, want.mode_code, want.digit_count,
                       want.keypad_number, want.digit_value, want.user_id,
                       want.numeric_overflow);
              $display({"record %0d mismatch: actual   st=%0d mode=%0d dc=%0d",
                        " kp=%h val=%h uid=%h ovf=%b"},
                       records_seen, got.status, got.mode_code, got.digit_count,
                       got.keypad_number, got.digit_value, got.user_id,
                       got.numeric_overflow);
            end
          end
        end
        records_seen++;
      end
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        absorb_byte(byte_mon_i.data_byte, byte_mon_i.last_byte);
      end
      fail_count_o <= fails;
      pending_o    <= expected_records.size();
    end
  end

endmodule

`default_nettype wire

@@ bench/keypad_report_decoder_test.sv @@
`default_nettype none

// Top of the keypad report decoder bench. It generates the clock and the one
// reset, feeds whole reports into the decoder one byte per transaction, drives
// the record channel's ready on a pattern of its own, and gives the verdict.
// Prediction and comparison live in the checker beside the decoder.
module keypad_report_decoder_test;

  localparam int unsigned MaxReportBytes = 64;
  localparam int unsigned RandomBytes    = 1900;  // parsed bytes in the random part
  localparam int unsigned LongHold       = 400;   // length of the long receiver hold-off
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned CycleLimit     = 500000;

  // Ways in which the receiver may behave for a while.
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyRhythm
  } ready_style_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  // Sender burst bookkeeping, owned by put_byte.
  int unsigned burst_left = 0;

  // Requests for a long hold-off are counted by the stimulus and served by the
  // receiver process, which compares against the number it has seen.
  int unsigned  hold_asks = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  ready_style_e style = ReadyAlways;
  int unsigned  style_left = 0;
  int unsigned  rhythm = 0;

  logic [7:0] report[$];

  kprd_in_if  byte_ch ();
  kprd_out_if rec_ch ();

  keypad_report_decoder #(
    .MAX_REPORT_BYTES(MaxReportBytes)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch.sink),
    .out_o (rec_ch.source)
  );

  kprd_checker #(
    .MAX_REPORT_BYTES(MaxReportBytes)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .byte_mon_i  (byte_ch),
    .rec_mon_i   (rec_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A run that does not finish well inside this many cycles has hung.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one byte to the report being built.
  function automatic void add_byte(input logic [7:0] b);
    report.insert(report.size(), b);
  endfunction

  // Offers one byte and returns at the edge where the transaction completes,
  // or later if a gap between bursts follows it. Valid is only lowered when a
  // gap follows, so it never drops and rises in one step.
  task automatic put_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Mostly short gaps, now and then a longer quiet spell, sometimes none.
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(8, 25);
        default: gap = $urandom_range(1, 5);
      endcase
      burst_left = $urandom_range(0, 30);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_report();
    foreach (report[i]) put_byte(report[i], i == report.size() - 1);
  endtask

  // Receiver: switches between styles of readiness every so often, and serves
  // the long hold-off when the stimulus asks for one. That hold-off lets the
  // decoder fill up so that it has to refuse further bytes.
  always @(posedge clk) begin
    if (!rst_n) begin
      rec_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rec_ch.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
      rec_ch.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style      = ready_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 300);
      end else begin
        style_left--;
      end
      rhythm++;
      case (style)
        ReadyAlways: rec_ch.ready <= 1'b1;
        ReadyCoin:   rec_ch.ready <= 1'($urandom_range(0, 1));
        ReadySparse: rec_ch.ready <= ($urandom_range(0, 3) == 0);
        ReadyRhythm: rec_ch.ready <= (rhythm % 3 != 0);
        default:     rec_ch.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    int unsigned kind;
    int unsigned pick;
    int unsigned digits;
    int unsigned keep;
    int unsigned reports_sent;
    int unsigned parsed_bytes;
    logic [7:0]  count;
    logic        nines;

    // Every input is known from time zero.
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    rec_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed reports. A lone final byte never reaches the header.
    report = '{8'h00};
    send_report();
    // The first header byte is wrong, so the rest of the report is ignored.
    report = '{8'h55, kprd_pkg::HeaderSecond, kprd_pkg::ModeByteVote};
    send_report();
    // An end marker inside the header leaves the header incomplete.
    report = '{kprd_pkg::HeaderFirst, kprd_pkg::EndMarker, kprd_pkg::HeaderSecond};
    send_report();
    // Command mode overrides the vote mode byte and brings a single digit;
    // a zero byte among the user bytes is skipped.
    report = '{kprd_pkg::HeaderFirst, kprd_pkg::HeaderSecond, kprd_pkg::ModeByteVote,
               kprd_pkg::CountCommand,
               8'h12, 8'h34, 8'h56, 8'h37, 8'h00, 8'h31};
    send_report();
    // All-ones bytes in the keypad, digit and user fields, then an end marker
    // that hides the byte after it.
    report = '{kprd_pkg::HeaderFirst, kprd_pkg::HeaderSecond, kprd_pkg::ModeByteChannel,
               8'h11, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h39, 8'hFF,
               kprd_pkg::EndMarker, 8'h31};
    send_report();

    // Random reports: mostly well formed with random content, the rest broken
    // headers and plain noise.
    reports_sent = 0;
    parsed_bytes = 0;
    while (parsed_bytes < RandomBytes) begin
      report.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_byte(kprd_pkg::HeaderFirst);
        add_byte(kprd_pkg::HeaderSecond);
        case ($urandom_range(0, 4))
          0:       add_byte(kprd_pkg::ModeByteVote);
          1:       add_byte(kprd_pkg::ModeByteExam);
          2:       add_byte(kprd_pkg::ModeByteJoin);
          3:       add_byte(kprd_pkg::ModeByteChannel);
          default: add_byte(any_byte());
        endcase
        // The count byte: usually biased, sometimes raw or command, rarely
        // huge so that digits run to the end of the report.
        pick = $urandom_range(0, 19);
        if (pick < 14) count = kprd_pkg::CountBias + 8'($urandom_range(0, 12));
        else if (pick < 19) count = 8'($urandom_range(0, 14));
        else count = any_byte();
        add_byte(count);
        repeat (3) add_byte(any_byte());
        if (count >= kprd_pkg::CountBias) digits = count - kprd_pkg::CountBias;
        else if (count == kprd_pkg::CountCommand) digits = 1;
        else digits = count;
        // Runs of nines push both accumulators past their range.
        nines = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < digits && report.size() < MaxReportBytes + 8; i++) begin
          if (nines) add_byte(kprd_pkg::AsciiZero + 8'd9);
          else if ($urandom_range(0, 9) == 0) add_byte(any_byte());
          else add_byte(kprd_pkg::AsciiZero + 8'($urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 12)) begin
          case ($urandom_range(0, 9))
            0:       add_byte(8'h00);
            1:       add_byte(any_byte());
            default: add_byte(nines ? kprd_pkg::AsciiZero + 8'd9
                                    : kprd_pkg::AsciiZero + 8'($urandom_range(0, 9)));
          endcase
        end
        if ($urandom_range(0, 19) == 0) begin
          report[$urandom_range(0, report.size() - 1)] = kprd_pkg::EndMarker;
        end
        if ($urandom_range(0, 19) == 0) begin
          keep = $urandom_range(1, 7);
          while (report.size() > keep) void'(report.pop_back());
        end
        // Now and then run past the position limit.
        if ($urandom_range(0, 24) == 0) begin
          keep = MaxReportBytes + $urandom_range(1, 12);
          while (report.size() < keep) add_byte(any_byte());
        end
      end else if (kind < 85) begin
        // Broken header: one of the two header bytes is usually right.
        if ($urandom_range(0, 1) == 1) begin
          add_byte(kprd_pkg::HeaderFirst);
          add_byte(8'($urandom_range(1, 255)));
        end else begin
          add_byte(any_byte());
          add_byte($urandom_range(0, 1) == 1 ? kprd_pkg::HeaderSecond : any_byte());
        end
        repeat ($urandom_range(0, 10)) add_byte(any_byte());
      end else begin
        repeat ($urandom_range(1, 12)) add_byte(any_byte());
      end

      // Ask for a long receiver hold-off now and then; bytes keep coming.
      if (reports_sent % 60 == 20) hold_asks <= hold_asks + 1;
      send_report();
      reports_sent++;
      parsed_bytes += (report.size() < MaxReportBytes) ? report.size() : MaxReportBytes;
    end

    byte_ch.valid <= 1'b0;
    // One edge first so that the final transaction is counted as pending.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/kprd_pkg.sv
hw/rtl/kprd_if.sv
hw/rtl/kprd_parser.sv
hw/rtl/kprd_out_stage.sv
hw/rtl/keypad_report_decoder.sv
bench/kprd_checker.sv
bench/keypad_report_decoder_test.sv
